### sv/tce_pkg.sv
// Shared constants and types for the text console engine.
package tce_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int OP_W     = 2;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int IDX_W    = 11;
	localparam int LOC_W    = 11;
	localparam int CELL_W   = 16;

	localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0F20;
	localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
	localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

endpackage

### sv/text_console_engine_core.sv
// Text console engine: character store, cursor, scroll and clear sequencer.
// One beat is taken when start is high and busy is low; each beat yields one result
// beat on done: a put without scroll or an unused opcode gives it in the cycle after
// acceptance, a read after the S_READ state. Clear and scroll run a pass over the
// whole store through one address counter and one RAM port pair, one cell a cycle,
// then S_DRAIN. After reset the same pass blanks the store, keeping busy high
// with no result beat; cfg writes are taken anytime.
// Results cannot be stalled: sample them in the cycle that done is high.
module text_console_engine_core import tce_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   opcode,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [IDX_W-1:0]  cell_index,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	output logic              done,
	output logic [LOC_W-1:0]  cursor_location,
	output logic [CELL_W-1:0] cell_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int SPAN  = CELLS - COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int LW    = $clog2(CELLS + 1);
	localparam int CW    = $clog2(COLUMNS + 1);
	localparam int RW    = $clog2(ROWS + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CLEAR  = 5'b00010,
		S_SCROLL = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_READ   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     ptr_q;
	logic              from_op_q;
	logic              wr_en_s1;
	logic              wr_blank_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [LW-1:0]     lin_q;
	logic [ATTR_W-1:0] attr_q;
	logic              done_q;
	logic [CELL_W-1:0] data_q;
	logic              rd_ok_q;

	logic              accept;
	logic              is_lf;
	logic              is_cr;
	logic              is_prt;
	logic [CW-1:0]     col_p1;
	logic [CW-1:0]     col_n;
	logic [RW-1:0]     row_n;
	logic [LW-1:0]     lin_n;
	logic              need_scroll;
	logic [AW+IDX_W-1:0] idx_wide;
	logic              idx_ok;
	logic [LW+LOC_W-1:0] loc_wide;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	assign busy            = (state_q != S_IDLE);
	assign accept          = start && (state_q == S_IDLE);
	assign done            = done_q;
	assign cell_data       = data_q;
	assign loc_wide        = {{LOC_W{1'b0}}, lin_q};
	assign cursor_location = loc_wide[LOC_W-1:0];

	assign idx_wide = {{AW{1'b0}}, cell_index};
	assign idx_ok   = (idx_wide < (AW+IDX_W)'(CELLS));

	assign is_lf  = (char_code == CH_LF);
	assign is_cr  = (char_code == CH_CR);
	assign is_prt = (char_code >= CH_PRINT_LO) && !char_code[CHAR_W-1];
	assign col_p1 = col_q + 1'b1;

	always_comb begin
		col_n = col_q;
		row_n = row_q;
		lin_n = lin_q;
		if (is_lf) begin
			col_n = '0;
			row_n = row_q + 1'b1;
			lin_n = lin_q - LW'(col_q) + LW'(COLUMNS);
		end else if (is_cr) begin
			col_n = '0;
			lin_n = lin_q - LW'(col_q);
		end else if (is_prt) begin
			lin_n = lin_q + 1'b1;
			if (col_p1 == CW'(COLUMNS)) begin
				col_n = '0;
				row_n = row_q + 1'b1;
			end else begin
				col_n = col_p1;
			end
		end
	end

	assign need_scroll = (row_n == RW'(ROWS));

	assign ram_we    = wr_en_s1 || (accept && (opcode == OP_PUT) && is_prt);
	assign ram_waddr = wr_en_s1 ? wr_addr_s1 : lin_q[AW-1:0];
	assign ram_wdata = wr_en_s1 ? (wr_blank_s1 ? BLANK_CELL : ram_rdata)
	                            : {attr_q, char_code};
	assign ram_raddr = (state_q == S_SCROLL) ? ptr_q + AW'(COLUMNS) : idx_wide[AW-1:0];

	tce_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1  <= ptr_q;
		wr_blank_s1 <= (state_q == S_CLEAR) || (ptr_q >= AW'(SPAN));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ptr_q     <= '0;
			from_op_q <= 1'b0;
			wr_en_s1  <= 1'b0;
			col_q     <= '0;
			row_q     <= '0;
			lin_q     <= '0;
			done_q    <= 1'b0;
			data_q    <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			wr_en_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_PUT: begin
								data_q <= '0;
								if (need_scroll) begin
									col_q     <= '0;
									row_q     <= RW'(ROWS - 1);
									lin_q     <= LW'(SPAN);
									ptr_q     <= '0;
									from_op_q <= 1'b1;
									state_q   <= S_SCROLL;
								end else begin
									col_q  <= col_n;
									row_q  <= row_n;
									lin_q  <= lin_n;
									done_q <= 1'b1;
								end
							end
							OP_CLEAR: begin
								col_q     <= '0;
								row_q     <= '0;
								lin_q     <= '0;
								ptr_q     <= '0;
								from_op_q <= 1'b1;
								data_q    <= '0;
								state_q   <= S_CLEAR;
							end
							OP_READ: begin
								rd_ok_q <= idx_ok;
								state_q <= S_READ;
							end
							default: begin
								data_q <= '0;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_CLEAR, S_SCROLL: begin
					wr_en_s1 <= 1'b1;
					if (ptr_q == AW'(CELLS - 1)) begin
						ptr_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					done_q  <= from_op_q;
					state_q <= S_IDLE;
				end
				S_READ: begin
					data_q  <= rd_ok_q ? ram_rdata : '0;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_idle_no_pass_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wr_en_s1)
		else $error("store pass write pending while idle");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (col_q < CW'(COLUMNS)) && (row_q < RW'(ROWS)))
		else $error("cursor outside the screen");

	a_linear_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (lin_q == LW'(row_q * COLUMNS + col_q)))
		else $error("linear cursor out of step with row and column");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode == OP_READ)) |=> (state_q == S_READ) ##1 done)
		else $error("read beat did not return a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_IDLE) || $past(accept))
		else $error("result beat during a store pass");

endmodule

### sv/tce_ram.sv
// Generic simple dual-port RAM with registered read.
module tce_ram import tce_pkg::*; #(
	parameter int WIDTH = CELL_W,
	parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
